// ===== rtl/core/hpts_pkg.sv =====
// Shared types and constants for the heading PID thrust split block.
// Holds the configuration record, register indexes and datapath step codes.
// No dependencies.
package hpts_pkg;

  localparam int HEAD_W  = 15;
  localparam int DIFF_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 24;
  localparam int MIX_W   = 25;
  localparam int THR_W   = 16;
  localparam int SPD_W   = 16;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Angles in 1/64 degree
  localparam logic signed [DIFF_W-1:0] HALF_TURN = 16'sd11520;
  localparam logic signed [DIFF_W-1:0] FULL_TURN = 16'sd23040;
  // 0.1 m/s in 1/1024 m/s, rounded down
  localparam logic [SPD_W-1:0] SPEED_THRESH = 16'd102;

  // Multiplier operand and product widths
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ISUM_W  = 32;
  localparam int ACC_W   = 36;

  localparam logic signed [ACC_W-1:0] MIX_ONE = 36'sd8388608;
  localparam logic [MIX_W-1:0] AMIX_FULL = 25'd16777216;

  typedef enum logic [2:0] {
    REG_TARGET_HEADING = 3'd0,
    REG_PROP_GAIN      = 3'd1,
    REG_INTEG_GAIN     = 3'd2,
    REG_DERIV_GAIN     = 3'd3,
    REG_INTEG_LIMIT    = 3'd4,
    REG_MIX_BIAS       = 3'd5,
    REG_TOTAL_THRUST   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [HEAD_W-1:0] target_heading;
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        integ_gain;
    logic [GAIN_W-1:0]        deriv_gain;
    logic [LIM_W-1:0]         integ_limit;
    logic signed [MIX_W-1:0]  mix_bias;
    logic [THR_W-1:0]         total_thrust;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_DIFF  = 4'd1,
    OP_WRAP  = 4'd2,
    OP_MUL_I = 4'd3,
    OP_MUL_P = 4'd4,
    OP_MUL_D = 4'd5,
    OP_SUM_P = 4'd6,
    OP_SUM_I = 4'd7,
    OP_CLAMP = 4'd8,
    OP_MUL_L = 4'd9,
    OP_MUL_R = 4'd10
  } dp_op_t;

  typedef struct packed {
    logic   load_in;
    logic   load_out;
    dp_op_t op;
  } dp_cmd_t;

endpackage

// ===== rtl/core/hpts_cfg_regs.sv =====
// APB-style configuration registers for the heading PID thrust split block.
// Depends on hpts_pkg for the register record and register indexes.
module hpts_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hpts_pkg::PADDR_W-1:0] paddr,
  input  logic [hpts_pkg::PDATA_W-1:0] pwdata,
  output logic [hpts_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output hpts_pkg::cfg_t               cfg
);

  hpts_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = hpts_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_heading <= 15'sd5760;
      cfg.prop_gain      <= 16'd583;
      cfg.integ_gain     <= 16'd0;
      cfg.deriv_gain     <= 16'd0;
      cfg.integ_limit    <= 24'd2097152;
      cfg.mix_bias       <= 25'sd0;
      cfg.total_thrust   <= 16'd4096;
    end else if (wr_en) begin
      unique case (idx)
        hpts_pkg::REG_TARGET_HEADING: cfg.target_heading <= pwdata[14:0];
        hpts_pkg::REG_PROP_GAIN:      cfg.prop_gain      <= pwdata[15:0];
        hpts_pkg::REG_INTEG_GAIN:     cfg.integ_gain     <= pwdata[15:0];
        hpts_pkg::REG_DERIV_GAIN:     cfg.deriv_gain     <= pwdata[15:0];
        hpts_pkg::REG_INTEG_LIMIT:    cfg.integ_limit    <= pwdata[23:0];
        hpts_pkg::REG_MIX_BIAS:       cfg.mix_bias       <= pwdata[24:0];
        hpts_pkg::REG_TOTAL_THRUST:   cfg.total_thrust   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hpts_pkg::REG_TARGET_HEADING: prdata = 32'(cfg.target_heading);
      hpts_pkg::REG_PROP_GAIN:      prdata = {16'd0, cfg.prop_gain};
      hpts_pkg::REG_INTEG_GAIN:     prdata = {16'd0, cfg.integ_gain};
      hpts_pkg::REG_DERIV_GAIN:     prdata = {16'd0, cfg.deriv_gain};
      hpts_pkg::REG_INTEG_LIMIT:    prdata = {8'd0, cfg.integ_limit};
      hpts_pkg::REG_MIX_BIAS:       prdata = 32'(cfg.mix_bias);
      hpts_pkg::REG_TOTAL_THRUST:   prdata = {16'd0, cfg.total_thrust};
      default:                      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/hpts_ctrl.sv =====
// Sequencer for the heading PID thrust split block: handshakes and step order.
// Depends on hpts_pkg for the datapath command record and step codes.
module hpts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output hpts_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  state_t           state;
  hpts_pkg::dp_op_t op;
  hpts_pkg::dp_op_t op_next;
  logic             load_in;
  logic             load_out;

  assign load_in  = in_valid & in_ready;
  assign load_out = (state == S_WAIT) & (~out_valid | out_ready);

  assign cmd = {load_in, load_out, op};

  always_comb begin
    unique case (op)
      hpts_pkg::OP_DIFF:  op_next = hpts_pkg::OP_WRAP;
      hpts_pkg::OP_WRAP:  op_next = hpts_pkg::OP_MUL_I;
      hpts_pkg::OP_MUL_I: op_next = hpts_pkg::OP_MUL_P;
      hpts_pkg::OP_MUL_P: op_next = hpts_pkg::OP_MUL_D;
      hpts_pkg::OP_MUL_D: op_next = hpts_pkg::OP_SUM_P;
      hpts_pkg::OP_SUM_P: op_next = hpts_pkg::OP_SUM_I;
      hpts_pkg::OP_SUM_I: op_next = hpts_pkg::OP_CLAMP;
      hpts_pkg::OP_CLAMP: op_next = hpts_pkg::OP_MUL_L;
      hpts_pkg::OP_MUL_L: op_next = hpts_pkg::OP_MUL_R;
      default:            op_next = hpts_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= hpts_pkg::OP_NONE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (load_in) begin
            state    <= S_RUN;
            op       <= hpts_pkg::OP_DIFF;
            in_ready <= 1'b0;
          end
        end
        S_RUN: begin
          op <= op_next;
          if (op == hpts_pkg::OP_MUL_R) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          // hold the finished request until the output register frees up
          if (load_out) begin
            out_valid <= 1'b1;
            in_ready  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/hpts_datapath.sv =====
// Datapath of the heading PID thrust split block: heading wrap, PID state,
// one shared 17x26 multiplier, mix clamp and thrust split. Depends on hpts_pkg.
module hpts_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  hpts_pkg::dp_cmd_t                  cmd,
  input  hpts_pkg::cfg_t                     cfg,
  input  logic signed [hpts_pkg::HEAD_W-1:0] velocity_heading,
  input  logic signed [hpts_pkg::HEAD_W-1:0] body_heading,
  input  logic [hpts_pkg::SPD_W-1:0]         horiz_speed,
  output logic [hpts_pkg::THR_W-1:0]         left_thrust,
  output logic [hpts_pkg::THR_W-1:0]         right_thrust,
  output logic signed [hpts_pkg::HEAD_W-1:0] heading_error,
  output logic                               mix_saturated
);

  localparam int HW = hpts_pkg::HEAD_W;
  localparam int DW = hpts_pkg::DIFF_W;
  localparam int AW = hpts_pkg::MUL_A_W;
  localparam int BW = hpts_pkg::MUL_B_W;
  localparam int PW = hpts_pkg::PROD_W;
  localparam int IW = hpts_pkg::ISUM_W;
  localparam int XW = hpts_pkg::ACC_W;
  localparam int MW = hpts_pkg::MIX_W;

  // PID state
  logic signed [HW-1:0] last_error;
  logic signed [MW-1:0] integ_accum;

  // working registers
  logic signed [HW-1:0] meas;
  logic signed [DW-1:0] diff;
  logic signed [HW-1:0] err;
  logic signed [DW-1:0] chg;
  logic signed [IW-1:0] integ_sum;
  logic signed [XW-1:0] mix;
  logic [MW-1:0]        amix;
  logic                 sat;
  logic signed [PW-1:0] prod;
  logic [hpts_pkg::THR_W-1:0] left_val;

  logic signed [DW-1:0] tgt;
  logic signed [DW-1:0] tgt_wrapped;
  logic signed [DW-1:0] diff_wrapped;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [PW-1:0] prod_rnd;
  logic signed [IW-1:0] lim;
  logic signed [XW-1:0] mix_off;

  assign tgt = DW'(cfg.target_heading);

  always_comb begin
    priority if (tgt < -hpts_pkg::HALF_TURN) begin
      tgt_wrapped = tgt + hpts_pkg::FULL_TURN;
    end else if (tgt >= hpts_pkg::HALF_TURN) begin
      tgt_wrapped = tgt - hpts_pkg::FULL_TURN;
    end else begin
      tgt_wrapped = tgt;
    end
  end

  always_comb begin
    priority if (diff < -hpts_pkg::HALF_TURN) begin
      diff_wrapped = diff + hpts_pkg::FULL_TURN;
    end else if (diff >= hpts_pkg::HALF_TURN) begin
      diff_wrapped = diff - hpts_pkg::FULL_TURN;
    end else begin
      diff_wrapped = diff;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.op)
      hpts_pkg::OP_MUL_I: begin
        mul_a = AW'(err);
        mul_b = BW'({1'b0, cfg.integ_gain});
      end
      hpts_pkg::OP_MUL_P: begin
        mul_a = AW'(err);
        mul_b = BW'({1'b0, cfg.prop_gain});
      end
      hpts_pkg::OP_MUL_D: begin
        mul_a = AW'(chg);
        mul_b = BW'({1'b0, cfg.deriv_gain});
      end
      hpts_pkg::OP_MUL_L: begin
        mul_a = AW'({1'b0, cfg.total_thrust});
        mul_b = BW'({1'b0, amix});
      end
      hpts_pkg::OP_MUL_R: begin
        mul_a = AW'({1'b0, cfg.total_thrust});
        mul_b = BW'({1'b0, hpts_pkg::AMIX_FULL - amix});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = PW'(mul_a) * PW'(mul_b);
  assign prod_rnd = prod + PW'(hpts_pkg::MIX_ONE);
  assign lim      = IW'({1'b0, cfg.integ_limit});
  assign mix_off  = mix + hpts_pkg::MIX_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error  <= '0;
      integ_accum <= '0;
    end else begin
      unique case (cmd.op)
        hpts_pkg::OP_MUL_D: begin
          priority if (integ_sum > lim) begin
            integ_accum <= MW'(lim);
          end else if (integ_sum < -lim) begin
            integ_accum <= MW'(-lim);
          end else begin
            integ_accum <= MW'(integ_sum);
          end
        end
        hpts_pkg::OP_SUM_P: last_error <= err;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      meas <= (horiz_speed > hpts_pkg::SPEED_THRESH) ? velocity_heading : body_heading;
    end
    unique case (cmd.op)
      hpts_pkg::OP_DIFF: diff <= DW'(meas) - tgt_wrapped;
      hpts_pkg::OP_WRAP: err <= HW'(diff_wrapped);
      hpts_pkg::OP_MUL_I: begin
        prod <= mul_p;
        chg  <= DW'(err) - DW'(last_error);
      end
      hpts_pkg::OP_MUL_P: begin
        integ_sum <= IW'(integ_accum) + IW'(prod);
        prod      <= mul_p;
      end
      hpts_pkg::OP_MUL_D: begin
        mix  <= XW'(prod) + XW'(cfg.mix_bias);
        prod <= mul_p;
      end
      hpts_pkg::OP_SUM_P: mix <= mix + XW'(prod);
      hpts_pkg::OP_SUM_I: mix <= mix + XW'(integ_accum);
      hpts_pkg::OP_CLAMP: begin
        priority if (mix > hpts_pkg::MIX_ONE) begin
          amix <= hpts_pkg::AMIX_FULL;
          sat  <= 1'b1;
        end else if (mix < -hpts_pkg::MIX_ONE) begin
          amix <= '0;
          sat  <= 1'b1;
        end else begin
          amix <= mix_off[MW-1:0];
          sat  <= 1'b0;
        end
      end
      hpts_pkg::OP_MUL_L: prod <= mul_p;
      hpts_pkg::OP_MUL_R: begin
        left_val <= prod_rnd[39:24];
        prod     <= mul_p;
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      left_thrust   <= left_val;
      right_thrust  <= prod_rnd[39:24];
      heading_error <= err;
      mix_saturated <= sat;
    end
  end

endmodule

// ===== rtl/core/heading_pid_thrust_split.sv =====
// Top level of the heading PID thrust split block.
// Depends on hpts_pkg, hpts_cfg_regs, hpts_ctrl and hpts_datapath.

// Heading-hold PID with a left/right thrust split. One request carries the
// velocity heading, body heading and horizontal speed; one result comes back
// with both thruster commands, the wrapped heading error and a saturation flag.
// A request runs through ten steps from acceptance to a valid result, and a new
// request is taken in the cycle after the result is loaded; the ten steps share
// a single 17x26 multiplier. The finished result sits in an output register,
// so the next request may be accepted while it waits; a stalled output only
// holds the block once a second result is ready. Configuration registers sit on
// an APB-style port at byte addresses 4*index and must be written while idle.
module heading_pid_thrust_split (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hpts_pkg::PADDR_W-1:0]       paddr,
  input  logic [hpts_pkg::PDATA_W-1:0]       pwdata,
  output logic [hpts_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [hpts_pkg::HEAD_W-1:0] velocity_heading,
  input  logic signed [hpts_pkg::HEAD_W-1:0] body_heading,
  input  logic [hpts_pkg::SPD_W-1:0]         horiz_speed,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hpts_pkg::THR_W-1:0]         left_thrust,
  output logic [hpts_pkg::THR_W-1:0]         right_thrust,
  output logic signed [hpts_pkg::HEAD_W-1:0] heading_error,
  output logic                               mix_saturated
);

  hpts_pkg::cfg_t    cfg;
  hpts_pkg::dp_cmd_t cmd;

  hpts_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hpts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  hpts_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg              (cfg),
    .velocity_heading (velocity_heading),
    .body_heading     (body_heading),
    .horiz_speed      (horiz_speed),
    .left_thrust      (left_thrust),
    .right_thrust     (right_thrust),
    .heading_error    (heading_error),
    .mix_saturated    (mix_saturated)
  );

endmodule
